### design/disk_scan_scheduler_top_defines.svh
// Assertion macros used by the scheduler top level
`ifndef DISK_SCAN_SCHEDULER_TOP_DEFINES_SVH
`define DISK_SCAN_SCHEDULER_TOP_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define DSS_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication, sampled on clk, disabled in reset
`define DSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### design/dss_pkg.sv
// Shared constants and types for the SCAN disk scheduler
package dss_pkg;

  localparam int SIZE_W = 16;   // disk_size register width
  localparam int MOV_W  = 17;   // total movement field width

  localparam logic [SIZE_W-1:0] DISK_SIZE_RST = 16'd200;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // control from the sequencer to the candidate picker
  typedef struct packed {
    logic clear;     // forget the current best
    logic cand_vld;  // read data from the store is on cand_key
    logic up;        // 1: ascending sweep, 0: descending sweep
  } pick_ctl_t;

endpackage

### design/disk_scan_scheduler_top.sv
// SCAN (elevator) disk scheduler: top level and sequencer
//
//  channel  | handshake               | beat contents
//  ---------+-------------------------+------------------------------------------
//  command  | start & !busy           | command, track_value
//  config   | cfg_valid & cfg_ready   | cfg_data (disk_size)
//  result   | result_valid (1 cycle)  | served_track, has_track, total_movement,
//           |                         | last, dropped
//
// Loads may follow back to back.
// A run over n stored requests makes n+2 passes (read each entry, drain, decide);
// an empty run goes from idle straight to decide; busy falls with the last beat.
// Every beat waits on a full pass because the store has a single read port.
// rst is synchronous: count, overflow flag and sequencer clear, disk_size returns to 200.
// The receiver cannot stall result beats; config is refused while busy or start is high.
`include "disk_scan_scheduler_top_defines.svh"

module disk_scan_scheduler_top import dss_pkg::*; #(
  parameter int MAX_REQUESTS = 32,
  parameter int TRACK_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  command,
  input  logic [TRACK_BITS-1:0] track_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SIZE_W-1:0]     cfg_data,
  output logic                  result_valid,
  output logic [TRACK_BITS-1:0] served_track,
  output logic                  has_track,
  output logic [MOV_W-1:0]      total_movement,
  output logic                  last,
  output logic                  dropped
);

  localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int KW = TRACK_BITS + IW + 1;
  localparam int VW = (TRACK_BITS > SIZE_W) ? TRACK_BITS : SIZE_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DECIDE} state_t;

  state_t                state;
  logic [SIZE_W-1:0]     disk_size;
  logic [CW-1:0]         req_count;
  logic                  overflow_seen;
  logic [IW-1:0]         scan_addr;
  logic                  rd_vld;
  logic [IW-1:0]         rd_idx;
  logic [TRACK_BITS-1:0] rd_data;
  logic [TRACK_BITS-1:0] head;
  logic [KW-1:0]         ref_key;
  logic                  up;
  logic                  phase;
  logic                  pend_vld;
  logic [TRACK_BITS-1:0] pend_track;
  logic [VW-1:0]         pos;
  logic [VW:0]           mov;

  logic [SIZE_W-1:0]     size_eff;
  logic [VW-1:0]         size_v;
  logic [VW-1:0]         size_m1;
  logic [VW-1:0]         track_ext;
  logic [VW-1:0]         clamped_v;
  logic [TRACK_BITS-1:0] clamped;
  logic                  accept;
  logic                  run_acc;
  logic                  load_acc;
  logic                  wr_en;
  logic                  scan_last;
  logic                  low_first;
  pick_ctl_t             pick_ctl;
  logic [KW-1:0]         cand_key;
  logic                  found;
  logic [KW-1:0]         best_key;
  logic [TRACK_BITS-1:0] best_val;
  logic [VW-1:0]         best_ext;
  logic [VW-1:0]         step;
  logic [VW-1:0]         turn_step;
  logic [KW-1:0]         head_key;

  // a disk size of zero behaves as one track
  assign size_eff  = (disk_size == '0) ? SIZE_W'(1) : disk_size;
  assign size_v    = VW'(size_eff);
  assign size_m1   = size_v - VW'(1);
  assign track_ext = VW'(track_value);
  assign clamped_v = (track_ext > size_m1) ? size_m1 : track_ext;
  assign clamped   = clamped_v[TRACK_BITS-1:0];
  assign low_first = ({1'b0, clamped_v} << 1) < {1'b0, size_v};

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign accept    = start && !busy;
  assign run_acc   = accept && (command == CMD_RUN);
  assign load_acc  = accept && (command == CMD_LOAD);
  assign wr_en     = load_acc && (req_count < CW'(MAX_REQUESTS));
  assign scan_last = ((CW'(scan_addr) + CW'(1)) == req_count);

  // head key with the index field above every real index: start of a sweep
  assign head_key  = {head, 1'b1, {IW{1'b0}}};
  assign cand_key  = {rd_data, 1'b0, rd_idx};

  assign pick_ctl.clear    = (state == S_DECIDE) || run_acc;
  assign pick_ctl.cand_vld = rd_vld;
  assign pick_ctl.up       = up;

  assign best_val  = best_key[KW-1 -: TRACK_BITS];
  assign best_ext  = VW'(best_val);
  assign step      = up ? (best_ext - pos) : (pos - best_ext);
  assign turn_step = up ? (size_v - pos) : pos;

  dss_req_mem #(
    .DEPTH (MAX_REQUESTS),
    .WIDTH (TRACK_BITS),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (req_count[IW-1:0]),
    .wr_data (clamped),
    .rd_en   (state == S_SCAN),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  dss_pick #(
    .KW (KW)
  ) u_pick (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pick_ctl),
    .cand_key (cand_key),
    .ref_key  (ref_key),
    .found    (found),
    .best_key (best_key)
  );

  // read pipeline tag: index of the entry arriving on rd_data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_SCAN);
    end
    rd_idx <= scan_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      disk_size     <= DISK_SIZE_RST;
      req_count     <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
      scan_addr     <= '0;
      pend_vld      <= 1'b0;
      phase         <= 1'b0;
      up            <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        disk_size <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (load_acc) begin
            if (wr_en) begin
              req_count <= req_count + CW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
          end else if (run_acc) begin
            head      <= clamped;
            ref_key   <= {clamped, 1'b1, {IW{1'b0}}};
            pos       <= clamped_v;
            mov       <= '0;
            up        <= !low_first;
            phase     <= 1'b0;
            pend_vld  <= 1'b0;
            scan_addr <= '0;
            state     <= (req_count == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_DRAIN;
          end else begin
            scan_addr <= scan_addr + IW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          scan_addr <= '0;
          if (found) begin
            mov        <= mov + (VW+1)'(step);
            pos        <= best_ext;
            ref_key    <= best_key;
            pend_vld   <= 1'b1;
            pend_track <= best_val;
            if (pend_vld) begin
              result_valid   <= 1'b1;
              served_track   <= pend_track;
              has_track      <= 1'b1;
              total_movement <= '0;
              last           <= 1'b0;
              dropped        <= overflow_seen;
            end
            state <= S_SCAN;
          end else if (!phase) begin
            // turn at the end of the disk, then sweep the other way
            mov     <= mov + (VW+1)'(turn_step);
            pos     <= up ? size_v : '0;
            up      <= !up;
            phase   <= 1'b1;
            ref_key <= head_key;
            state   <= (req_count == '0) ? S_DECIDE : S_SCAN;
          end else begin
            result_valid   <= 1'b1;
            served_track   <= pend_vld ? pend_track : '0;
            has_track      <= pend_vld;
            total_movement <= mov[MOV_W-1:0];
            last           <= 1'b1;
            dropped        <= overflow_seen;
            req_count      <= '0;
            overflow_seen  <= 1'b0;
            pend_vld       <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DSS_ASSERT_IMPL(a_beat_in_run, result_valid, $past(busy), "result beat outside a run")
  `DSS_ASSERT_IMPL(a_last_clears, result_valid && last, {req_count, overflow_seen} == '0, "store kept")
  `DSS_ASSERT_HOLDS(a_count_bound, req_count <= CW'(MAX_REQUESTS), "request count beyond capacity")
  `DSS_ASSERT_IMPL(a_empty_last, result_valid && !has_track, last && served_track == '0, "bad empty")

endmodule

### design/dss_req_mem.sv
// Request store: one write port, one registered read port
module dss_req_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // loads happen only while no scan runs, so read and write never collide
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/dss_pick.sv
// Candidate picker: nearest key beyond the reference in the sweep direction
module dss_pick import dss_pkg::*; #(
  parameter int KW = 22
) (
  input  logic          clk,
  input  logic          rst,
  input  pick_ctl_t     ctl,
  input  logic [KW-1:0] cand_key,
  input  logic [KW-1:0] ref_key,
  output logic          found,
  output logic [KW-1:0] best_key
);

  logic qual;
  logic better;

  // keys are {track, head flag, index}; the index breaks ties between equal tracks
  assign qual   = ctl.up ? (cand_key > ref_key) : (cand_key < ref_key);
  assign better = !found || (ctl.up ? (cand_key < best_key) : (cand_key > best_key));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.cand_vld && qual && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl.clear && ctl.cand_vld && qual && better) begin
      best_key <= cand_key;
    end
  end

endmodule
